// ===== rtl/core/packed_gate_netlist_evaluator_unit_assert.svh =====
// assertion macros shared by the evaluator checker
`ifndef PACKED_GATE_NETLIST_EVALUATOR_UNIT_ASSERT_SVH
`define PACKED_GATE_NETLIST_EVALUATOR_UNIT_ASSERT_SVH

// clocked property, switched off while reset is low
`define PGNE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgne assertion failed");

// clocked property that also holds across reset
`define PGNE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pgne assertion failed");

`endif

// ===== rtl/core/pgne_pkg.sv =====
// shared constants, codes and types of the packed gate netlist evaluator
`default_nettype none

package pgne_pkg;

  localparam int WORD_W       = 32;
  localparam int DEF_GATES    = 65536;
  localparam int DEF_LANES    = 32;
  localparam int MSG_ENTRIES  = 512;
  localparam int CHN_ENTRIES  = 256;
  localparam int DATA_ENTRIES = MSG_ENTRIES + CHN_ENTRIES;
  localparam int DATA_AW      = $clog2(DATA_ENTRIES);
  localparam int REF_W        = 16;
  localparam int PIN_COUNT    = 4;

  // item opcodes
  localparam logic [1:0] OPC_LOAD_MSG = 2'd0;
  localparam logic [1:0] OPC_LOAD_CHN = 2'd1;
  localparam logic [1:0] OPC_EXEC     = 2'd2;

  // gate operations
  localparam logic [1:0] GOP_XOR3   = 2'd0;
  localparam logic [1:0] GOP_CHOOSE = 2'd1;
  localparam logic [1:0] GOP_MAJ    = 2'd2;
  localparam logic [1:0] GOP_ADD    = 2'd3;

  // operand source selectors; pin selectors are the pin numbers themselves
  localparam logic [2:0] SEL_MSG  = 3'd4;
  localparam logic [2:0] SEL_CHN  = 3'd5;
  localparam logic [2:0] SEL_KEEP = 3'd6;

  // pin positions inside one gate row
  localparam logic [1:0] PIN_A   = 2'd0;
  localparam logic [1:0] PIN_B   = 2'd1;
  localparam logic [1:0] PIN_C   = 2'd2;
  localparam logic [1:0] PIN_OUT = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PIN_COUNT-1:0][WORD_W-1:0] pin_row_t;
  typedef logic [PIN_COUNT-1:0] pin_mask_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED1,
    ST_RED2,
    ST_RD_A,
    ST_OP_B,
    ST_OP_C,
    ST_EVAL,
    ST_CARRY
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pgne_gidx.sv =====
// three-stage reduction of a 16-bit gate number modulo the gate count
`default_nettype none

module pgne_gidx #(
  parameter int GATES   = pgne_pkg::DEF_GATES,
  parameter int GATE_AW = $clog2(GATES)
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [pgne_pkg::REF_W-1:0]   idx,
  output logic      [GATE_AW-1:0]           gate
);

  localparam int RW = pgne_pkg::REF_W;
  // floor(2^32 / GATES); the quotient estimate is exact or one low
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / GATES);
  localparam logic [31:0] GATES_W = 32'(GATES);

  logic [RW+31:0] prod_r;
  logic [RW-1:0]  x1_r;
  logic [RW-1:0]  qg_r;
  logic [RW-1:0]  x2_r;
  logic [GATE_AW-1:0] gate_r;

  logic [RW-1:0] q;
  logic [RW-1:0] qg_nxt;
  logic [RW-1:0] diff;
  logic [RW-1:0] rem;

  always_comb begin
    q      = prod_r[RW+31:32];
    qg_nxt = RW'({16'd0, q} * GATES_W);
    diff   = x2_r - qg_r;
    if ({16'd0, diff} >= GATES_W) begin
      rem = diff - GATES_W[RW-1:0];
    end else begin
      rem = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= idx * RECIP;
      x1_r   <= idx;
      qg_r   <= qg_nxt;
      x2_r   <= x1_r;
      gate_r <= GATE_AW'(rem);
    end
  end

  assign gate = gate_r;

endmodule

`default_nettype wire

// ===== rtl/core/packed_gate_netlist_evaluator_unit.sv =====
// top level of the packed gate netlist evaluator: gate row memory, data memory, sequencer
//
// channel   ports                     handshake
// input     in_* fields               accepted when start is high and busy is low
// result    out_* fields              out_valid high for one cycle, always taken
//
// loads write the data memory at the accept edge and leave busy low
// an execute item stays busy after accept through the gate number reduction (RED1,
//   RED2), the issue of the operand reads from the gate row memory (RD_A, OP_B, OP_C),
//   evaluation and result write (EVAL) and, for add, the carry write to the next gate's
//   row (CARRY), all through its single write port
// the result strobe is registered out of the EVAL state
// after reset the gate row memory is swept, one row per cycle, with busy high
// results never stall; the result register frees the input side, for add after CARRY
`default_nettype none

module packed_gate_netlist_evaluator_unit #(
  parameter int GATES = pgne_pkg::DEF_GATES,
  parameter int LANES = pgne_pkg::DEF_LANES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [8:0]  in_load_index,
  input  wire logic [31:0] in_load_value,
  input  wire logic [1:0]  in_gate_op,
  input  wire logic [15:0] in_gate_ref,
  input  wire logic [2:0]  in_src1_sel,
  input  wire logic [15:0] in_src1_index,
  input  wire logic [2:0]  in_src2_sel,
  input  wire logic [15:0] in_src2_index,
  input  wire logic [2:0]  in_src3_sel,
  input  wire logic [15:0] in_src3_index,
  output logic             out_valid,
  output logic [15:0]      out_ref,
  output logic [31:0]      out_operand_a,
  output logic [31:0]      out_operand_b,
  output logic [31:0]      out_operand_c,
  output logic [31:0]      out_gate_result,
  output logic             out_carry_valid,
  output logic [31:0]      out_carry_word
);

  localparam int GATE_AW = $clog2(GATES);
  localparam int DATA_AW = pgne_pkg::DATA_AW;
  localparam logic [GATE_AW-1:0] LAST_GATE = GATE_AW'(GATES - 1);
  // constant gate value: all lanes one
  localparam pgne_pkg::word_t ALL_LANES = pgne_pkg::word_t'((64'd1 << LANES) - 64'd1);
  localparam logic [DATA_AW-1:0] CHN_BASE = DATA_AW'(pgne_pkg::MSG_ENTRIES);

  // sequencer
  pgne_pkg::state_t state_r, state_nxt;
  logic [GATE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // captured execute item
  logic [1:0]  gate_op_r;
  logic [2:0]  sel1_r, sel2_r, sel3_r;
  logic [15:0] idx1_r, idx2_r, idx3_r;

  // reduced gate numbers
  logic [GATE_AW-1:0] g;
  logic [GATE_AW-1:0] sg1, sg2, sg3;
  logic [GATE_AW-1:0] g_next;
  logic               red_en;

  // memories: one row of four pins per gate, one word store for message and chain entries
  pgne_pkg::pin_row_t pin_mem [GATES];
  pgne_pkg::pin_row_t pin_rd_r;
  pgne_pkg::word_t    data_mem [pgne_pkg::DATA_ENTRIES];
  pgne_pkg::word_t    data_rd_r;

  logic [GATE_AW-1:0]  pin_waddr;
  pgne_pkg::pin_mask_t pin_wmask;
  pgne_pkg::pin_row_t  pin_wdata;
  logic [DATA_AW-1:0]  data_waddr;
  logic                data_we;
  logic [DATA_AW-1:0]  data_raddr;

  // operand read issue
  logic [1:0]         iss_pos;
  logic [2:0]         iss_sel;
  logic [15:0]        iss_idx;
  logic [GATE_AW-1:0] iss_sg;
  logic               iss_keep;
  logic               iss_is_pin;
  logic [1:0]         iss_pin;
  logic [GATE_AW-1:0] iss_gate;
  logic               iss_fwd_ok;
  logic [1:0]         wr_pin_now;

  // returned operand
  logic            rd_is_pin_r;
  logic [1:0]      rd_pin_r;
  logic            fwd_r, fwd_nxt;
  pgne_pkg::word_t fwd_val_r;
  pgne_pkg::word_t opv;

  pgne_pkg::word_t a_r, b_r, cw_r;
  pgne_pkg::word_t res_word, carry_word;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_ref_r;
  pgne_pkg::word_t out_a_r, out_b_r, out_c_r, out_res_r, out_cw_r;
  logic            out_cv_r;

  logic accept;
  logic exec_accept;

  assign accept      = start && !busy;
  assign exec_accept = accept && (in_opcode == pgne_pkg::OPC_EXEC);

  // gate number reduction, held once the pipeline has filled
  pgne_gidx #(.GATES(GATES), .GATE_AW(GATE_AW)) u_red_g (
    .clk(clk), .en(red_en), .idx(in_gate_ref), .gate(g)
  );
  pgne_gidx #(.GATES(GATES), .GATE_AW(GATE_AW)) u_red_s1 (
    .clk(clk), .en(red_en), .idx(in_src1_index), .gate(sg1)
  );
  pgne_gidx #(.GATES(GATES), .GATE_AW(GATE_AW)) u_red_s2 (
    .clk(clk), .en(red_en), .idx(in_src2_index), .gate(sg2)
  );
  pgne_gidx #(.GATES(GATES), .GATE_AW(GATE_AW)) u_red_s3 (
    .clk(clk), .en(red_en), .idx(in_src3_index), .gate(sg3)
  );

  assign g_next = (g == LAST_GATE) ? '0 : g + GATE_AW'(1);

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      pgne_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + GATE_AW'(1);
        if (clr_cnt_r == LAST_GATE) begin
          state_nxt = pgne_pkg::ST_IDLE;
        end
      end
      pgne_pkg::ST_IDLE: begin
        if (exec_accept) begin
          state_nxt = pgne_pkg::ST_RED1;
        end
      end
      pgne_pkg::ST_RED1: state_nxt = pgne_pkg::ST_RED2;
      pgne_pkg::ST_RED2: state_nxt = pgne_pkg::ST_RD_A;
      pgne_pkg::ST_RD_A: state_nxt = pgne_pkg::ST_OP_B;
      pgne_pkg::ST_OP_B: state_nxt = pgne_pkg::ST_OP_C;
      pgne_pkg::ST_OP_C: state_nxt = pgne_pkg::ST_EVAL;
      pgne_pkg::ST_EVAL: begin
        if (gate_op_r == pgne_pkg::GOP_ADD) begin
          state_nxt = pgne_pkg::ST_CARRY;
        end else begin
          state_nxt = pgne_pkg::ST_IDLE;
        end
      end
      pgne_pkg::ST_CARRY: state_nxt = pgne_pkg::ST_IDLE;
      default:            state_nxt = pgne_pkg::ST_IDLE;
    endcase
  end

  // operand value arriving from the previous read, with forwarding of the pin
  // written in the same cycle that read was issued
  always_comb begin
    if (fwd_r) begin
      opv = fwd_val_r;
    end else if (rd_is_pin_r) begin
      opv = pin_rd_r[rd_pin_r];
    end else begin
      opv = data_rd_r;
    end
  end

  // gate evaluation on a, b and the third operand arriving now
  always_comb begin
    carry_word = '0;
    case (gate_op_r)
      pgne_pkg::GOP_XOR3:   res_word = a_r ^ b_r ^ opv;
      pgne_pkg::GOP_CHOOSE: res_word = (a_r & b_r) ^ (~a_r & opv);
      pgne_pkg::GOP_MAJ:    res_word = (a_r & b_r) ^ (a_r & opv) ^ (b_r & opv);
      pgne_pkg::GOP_ADD: begin
        res_word   = a_r ^ b_r ^ opv;
        carry_word = (~a_r & b_r & opv) | (a_r & b_r) | (a_r & opv);
      end
      default: res_word = a_r ^ b_r ^ opv;
    endcase
  end

  // per-state outputs: busy, read issue, write port
  always_comb begin
    busy          = (state_r != pgne_pkg::ST_IDLE);
    red_en        = exec_accept || (state_r == pgne_pkg::ST_RED1) ||
                    (state_r == pgne_pkg::ST_RED2);
    out_valid_nxt = (state_r == pgne_pkg::ST_EVAL);
    iss_pos       = pgne_pkg::PIN_A;
    iss_sel       = sel1_r;
    iss_idx       = idx1_r;
    iss_sg        = sg1;
    iss_fwd_ok    = 1'b0;
    wr_pin_now    = pgne_pkg::PIN_A;
    pin_waddr     = g;
    pin_wmask     = '0;
    pin_wdata     = {pgne_pkg::PIN_COUNT{opv}};
    case (state_r)
      pgne_pkg::ST_CLEAR: begin
        pin_waddr = clr_cnt_r;
        pin_wmask = '1;
        pin_wdata = '0;
        // gate 0 is the constant gate
        if (clr_cnt_r == '0) begin
          pin_wdata[pgne_pkg::PIN_B]   = ALL_LANES;
          pin_wdata[pgne_pkg::PIN_OUT] = ALL_LANES;
        end
      end
      pgne_pkg::ST_OP_B: begin
        iss_pos    = pgne_pkg::PIN_B;
        iss_sel    = sel2_r;
        iss_idx    = idx2_r;
        iss_sg     = sg2;
        iss_fwd_ok = 1'b1;
        wr_pin_now = pgne_pkg::PIN_A;
        pin_wmask[pgne_pkg::PIN_A] = 1'b1;
      end
      pgne_pkg::ST_OP_C: begin
        iss_pos    = pgne_pkg::PIN_C;
        iss_sel    = sel3_r;
        iss_idx    = idx3_r;
        iss_sg     = sg3;
        iss_fwd_ok = 1'b1;
        wr_pin_now = pgne_pkg::PIN_B;
        pin_wmask[pgne_pkg::PIN_B] = 1'b1;
      end
      pgne_pkg::ST_EVAL: begin
        pin_wmask[pgne_pkg::PIN_C]   = 1'b1;
        pin_wmask[pgne_pkg::PIN_OUT] = 1'b1;
        pin_wdata[pgne_pkg::PIN_OUT] = res_word;
      end
      pgne_pkg::ST_CARRY: begin
        // carry goes to the third pin of the next gate
        pin_waddr = g_next;
        pin_wmask[pgne_pkg::PIN_C] = 1'b1;
        pin_wdata[pgne_pkg::PIN_C] = cw_r;
      end
      default: begin
      end
    endcase
  end

  // source decode of the operand being issued
  always_comb begin
    iss_keep   = (iss_sel >= pgne_pkg::SEL_KEEP);
    iss_is_pin = iss_keep || (iss_sel < pgne_pkg::SEL_MSG);
    iss_pin    = iss_keep ? iss_pos : iss_sel[1:0];
    iss_gate   = iss_keep ? g : iss_sg;
    if (iss_sel == pgne_pkg::SEL_CHN) begin
      data_raddr = CHN_BASE | DATA_AW'(iss_idx[7:0]);
    end else begin
      data_raddr = DATA_AW'(iss_idx[8:0]);
    end
    fwd_nxt = iss_fwd_ok && iss_is_pin && (iss_pin == wr_pin_now) && (iss_gate == g);
  end

  // loads write at the accept edge; chain entries above the store are dropped
  always_comb begin
    data_we    = 1'b0;
    data_waddr = DATA_AW'(in_load_index);
    if (accept && (in_opcode == pgne_pkg::OPC_LOAD_MSG)) begin
      data_we = 1'b1;
    end else if (accept && (in_opcode == pgne_pkg::OPC_LOAD_CHN) && !in_load_index[8]) begin
      data_we    = 1'b1;
      data_waddr = CHN_BASE | DATA_AW'(in_load_index[7:0]);
    end
  end

  // gate row memory, per-pin write enables
  always_ff @(posedge clk) begin
    for (int k = 0; k < pgne_pkg::PIN_COUNT; k++) begin
      if (pin_wmask[k]) begin
        pin_mem[pin_waddr][k] <= pin_wdata[k];
      end
    end
    pin_rd_r <= pin_mem[iss_gate];
  end

  // message and chain word memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= in_load_value;
    end
    data_rd_r <= data_mem[data_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgne_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  // item and operand payload
  always_ff @(posedge clk) begin
    if (exec_accept) begin
      gate_op_r <= in_gate_op;
      sel1_r    <= in_src1_sel;
      sel2_r    <= in_src2_sel;
      sel3_r    <= in_src3_sel;
      idx1_r    <= in_src1_index;
      idx2_r    <= in_src2_index;
      idx3_r    <= in_src3_index;
    end
    rd_is_pin_r <= iss_is_pin;
    rd_pin_r    <= iss_pin;
    fwd_val_r   <= opv;
    if (state_r == pgne_pkg::ST_OP_B) begin
      a_r <= opv;
    end
    if (state_r == pgne_pkg::ST_OP_C) begin
      b_r <= opv;
    end
    if (state_r == pgne_pkg::ST_EVAL) begin
      cw_r      <= carry_word;
      out_ref_r <= 16'(g);
      out_a_r   <= a_r;
      out_b_r   <= b_r;
      out_c_r   <= opv;
      out_res_r <= res_word;
      out_cv_r  <= (gate_op_r == pgne_pkg::GOP_ADD);
      out_cw_r  <= carry_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ref         = out_ref_r;
  assign out_operand_a   = out_a_r;
  assign out_operand_b   = out_b_r;
  assign out_operand_c   = out_c_r;
  assign out_gate_result = out_res_r;
  assign out_carry_valid = out_cv_r;
  assign out_carry_word  = out_cw_r;

endmodule

`default_nettype wire

// ===== rtl/core/pgne_checker.sv =====
// port-level checker of the evaluator and its bind
`default_nettype none

`include "packed_gate_netlist_evaluator_unit_assert.svh"

module pgne_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_carry_valid,
  input wire logic [31:0] out_carry_word
);

  logic exec_acc;
  logic load_acc;

  assign exec_acc = start && !busy && (in_opcode == pgne_pkg::OPC_EXEC);
  assign load_acc = start && !busy && (in_opcode != pgne_pkg::OPC_EXEC);

  // execute result comes out a fixed time after accept
  `PGNE_ASSERT(a_exec_latency, clk, rst_n, exec_acc |-> ##7 out_valid)
  // one strobe per item
  `PGNE_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid)
  // loads finish at the accept edge
  `PGNE_ASSERT(a_load_no_busy, clk, rst_n, load_acc |=> !busy)
  // non-add results carry no carry word
  `PGNE_ASSERT(a_carry_zero, clk, rst_n,
    (out_valid && !out_carry_valid) |-> (out_carry_word == 32'd0))
  // reset starts the memory sweep and drops the strobe
  `PGNE_ASSERT_ALWAYS(a_reset_sweep, clk, !rst_n |=> (busy && !out_valid))

endmodule

bind packed_gate_netlist_evaluator_unit pgne_checker u_pgne_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_carry_valid (out_carry_valid),
  .out_carry_word  (out_carry_word)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of the packed gate netlist evaluator unit
module testbench;
  import pgne_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] OPC_UNUSED   = 2'd3;
  localparam logic [2:0] SEL_KEEP_ALT = 3'd7;
  localparam logic [2:0] SRC_PIN_A    = {1'b0, PIN_A};
  localparam logic [2:0] SRC_PIN_B    = {1'b0, PIN_B};
  localparam logic [2:0] SRC_PIN_C    = {1'b0, PIN_C};
  localparam logic [2:0] SRC_PIN_OUT  = {1'b0, PIN_OUT};

  localparam word_t LANE_MASK    = word_t'((64'd1 << DEF_LANES) - 64'd1);
  // the clearing sweep after reset keeps busy high while it clears every gate row
  localparam int    STALL_LIMIT  = 4 * DEF_GATES;
  localparam int    DRAIN_CYCLES = 16;
  localparam int    RANDOM_ITEMS = 1900;
  localparam int    MAX_REPORTS  = 10;

  typedef struct {
    logic [1:0]  opcode;
    logic [8:0]  load_index;
    word_t       load_value;
    logic [1:0]  gate_op;
    logic [15:0] gate_ref;
    logic [2:0]  src1_sel;
    logic [15:0] src1_index;
    logic [2:0]  src2_sel;
    logic [15:0] src2_index;
    logic [2:0]  src3_sel;
    logic [15:0] src3_index;
  } gate_item_t;

  typedef struct {
    logic [15:0] gate_ref;
    word_t       operand_a;
    word_t       operand_b;
    word_t       operand_c;
    word_t       gate_result;
    logic        carry_valid;
    word_t       carry_word;
  } gate_outcome_t;

  // mirrors the message, chain and gate pin stores and holds the outcomes still to come
  class gate_tracker;
    bit [WORD_W-1:0] msg_words   [MSG_ENTRIES];
    bit [WORD_W-1:0] chain_words [CHN_ENTRIES];
    bit [WORD_W-1:0] pin_a_words [DEF_GATES];
    bit [WORD_W-1:0] pin_b_words [DEF_GATES];
    bit [WORD_W-1:0] pin_c_words [DEF_GATES];
    bit [WORD_W-1:0] out_words   [DEF_GATES];
    gate_outcome_t   expected_gates [$];
    int              fails;

    function new();
      // gate 0 is the constant gate
      pin_b_words[0] = LANE_MASK;
      out_words[0]   = LANE_MASK;
      fails          = 0;
    endfunction

    function word_t fetch_operand(logic [2:0] sel, logic [15:0] idx, logic [1:0] pos, int g);
      int src_gate;
      src_gate = int'(idx) % DEF_GATES;
      case (sel)
        SRC_PIN_A:   return pin_a_words[src_gate];
        SRC_PIN_B:   return pin_b_words[src_gate];
        SRC_PIN_C:   return pin_c_words[src_gate];
        SRC_PIN_OUT: return out_words[src_gate];
        SEL_MSG:     return msg_words[int'(idx) % MSG_ENTRIES];
        SEL_CHN:     return chain_words[int'(idx) % CHN_ENTRIES];
        default: begin
          // keep the gate's own stored pin
          if (pos == PIN_A) return pin_a_words[g];
          if (pos == PIN_B) return pin_b_words[g];
          return pin_c_words[g];
        end
      endcase
    endfunction

    function void take_item(gate_item_t it);
      int            g;
      word_t         a;
      word_t         b;
      word_t         c;
      word_t         r;
      word_t         cw;
      gate_outcome_t want;
      case (it.opcode)
        OPC_LOAD_MSG: msg_words[int'(it.load_index) % MSG_ENTRIES] = it.load_value;
        OPC_LOAD_CHN: begin
          if (it.load_index < CHN_ENTRIES) chain_words[it.load_index] = it.load_value;
        end
        OPC_EXEC: begin
          g = int'(it.gate_ref) % DEF_GATES;
          // operands are stored one after another, so later ones see earlier writes
          a = fetch_operand(it.src1_sel, it.src1_index, PIN_A, g);
          pin_a_words[g] = a;
          b = fetch_operand(it.src2_sel, it.src2_index, PIN_B, g);
          pin_b_words[g] = b;
          c = fetch_operand(it.src3_sel, it.src3_index, PIN_C, g);
          pin_c_words[g] = c;
          cw = '0;
          case (it.gate_op)
            GOP_XOR3:   r = a ^ b ^ c;
            GOP_CHOOSE: r = (a & b) ^ (~a & c);
            GOP_MAJ:    r = (a & b) ^ (a & c) ^ (b & c);
            default: begin
              r  = a ^ b ^ c;
              cw = (~a & b & c) | (a & b) | (a & c);
            end
          endcase
          out_words[g] = r;
          if (it.gate_op == GOP_ADD) pin_c_words[(g + 1) % DEF_GATES] = cw;
          want.gate_ref    = 16'(g);
          want.operand_a   = a;
          want.operand_b   = b;
          want.operand_c   = c;
          want.gate_result = r;
          want.carry_valid = (it.gate_op == GOP_ADD);
          want.carry_word  = cw;
          expected_gates = {expected_gates, want};
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, word_t want, word_t got);
      fails++;
      if (fails <= MAX_REPORTS)
        $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    function void match_result(gate_outcome_t got);
      gate_outcome_t want;
      if (expected_gates.size() == 0) begin
        flag("unexpected result for gate", '0, word_t'(got.gate_ref));
        return;
      end
      want = expected_gates.pop_front();
      if (got.gate_ref !== want.gate_ref)
        flag("gate number", word_t'(want.gate_ref), word_t'(got.gate_ref));
      if (got.operand_a !== want.operand_a) flag("operand a", want.operand_a, got.operand_a);
      if (got.operand_b !== want.operand_b) flag("operand b", want.operand_b, got.operand_b);
      if (got.operand_c !== want.operand_c) flag("operand c", want.operand_c, got.operand_c);
      if (got.gate_result !== want.gate_result)
        flag("gate result", want.gate_result, got.gate_result);
      if (got.carry_valid !== want.carry_valid)
        flag("carry valid", word_t'(want.carry_valid), word_t'(got.carry_valid));
      if (got.carry_word !== want.carry_word)
        flag("carry word", want.carry_word, got.carry_word);
    endfunction

    function int pending();
      return expected_gates.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        out_valid;
  logic [15:0] out_ref;
  logic [31:0] out_operand_a;
  logic [31:0] out_operand_b;
  logic [31:0] out_operand_c;
  logic [31:0] out_gate_result;
  logic        out_carry_valid;
  logic [31:0] out_carry_word;

  gate_item_t  drive_item;
  gate_tracker tracker;
  int          idle_pct;
  int          last_add_gate;
  int          quiet_cycles;
  bit          msg_seen   [MSG_ENTRIES];
  bit          chain_seen [CHN_ENTRIES];
  int          msg_loaded   [$];
  int          chain_loaded [$];

  packed_gate_netlist_evaluator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (drive_item.opcode),
    .in_load_index   (drive_item.load_index),
    .in_load_value   (drive_item.load_value),
    .in_gate_op      (drive_item.gate_op),
    .in_gate_ref     (drive_item.gate_ref),
    .in_src1_sel     (drive_item.src1_sel),
    .in_src1_index   (drive_item.src1_index),
    .in_src2_sel     (drive_item.src2_sel),
    .in_src2_index   (drive_item.src2_index),
    .in_src3_sel     (drive_item.src3_sel),
    .in_src3_index   (drive_item.src3_index),
    .out_valid       (out_valid),
    .out_ref         (out_ref),
    .out_operand_a   (out_operand_a),
    .out_operand_b   (out_operand_b),
    .out_operand_c   (out_operand_c),
    .out_gate_result (out_gate_result),
    .out_carry_valid (out_carry_valid),
    .out_carry_word  (out_carry_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one process samples both sides, results first, so no ordering within a step matters
  always @(posedge clk) begin : sample_ports
    gate_outcome_t seen;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      seen.gate_ref    = out_ref;
      seen.operand_a   = out_operand_a;
      seen.operand_b   = out_operand_b;
      seen.operand_c   = out_operand_c;
      seen.gate_result = out_gate_result;
      seen.carry_valid = out_carry_valid;
      seen.carry_word  = out_carry_word;
      tracker.match_result(seen);
    end
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) tracker.take_item(drive_item);
    // watchdog on cycles where neither side moves an item
    if (rst_n === 1'b1 && ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[packed_gate_netlist_evaluator_unit] ERROR");
      $finish;
    end
  end

  function automatic gate_item_t make_exec(logic [1:0] op, logic [15:0] gref,
                                           logic [2:0] s1, logic [15:0] i1,
                                           logic [2:0] s2, logic [15:0] i2,
                                           logic [2:0] s3, logic [15:0] i3);
    gate_item_t it;
    it.opcode     = OPC_EXEC;
    it.load_index = 9'($urandom);
    it.load_value = $urandom();
    it.gate_op    = op;
    it.gate_ref   = gref;
    it.src1_sel   = s1;
    it.src1_index = i1;
    it.src2_sel   = s2;
    it.src2_index = i2;
    it.src3_sel   = s3;
    it.src3_index = i3;
    return it;
  endfunction

  // loads and the unused opcode carry random gate fields that must not matter
  function automatic gate_item_t make_load(logic [1:0] opc, int idx, word_t val);
    gate_item_t it;
    it = make_exec(2'($urandom), 16'($urandom), 3'($urandom), 16'($urandom),
                   3'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
    it.opcode     = opc;
    it.load_index = 9'(idx);
    it.load_value = val;
    return it;
  endfunction

  // mostly a small pool so pins get reused, with the top end for the carry wrap
  function automatic logic [15:0] pick_gate();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 16'($urandom_range(31));
    if (roll < 90) return 16'(16'hFFFF - $urandom_range(1));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // store reads only name entries loaded since reset; index high bits wrap
  function automatic void pick_source(output logic [2:0] sel, output logic [15:0] idx);
    int roll;
    roll = $urandom_range(99);
    if (roll < 20 && msg_loaded.size() > 0) begin
      sel = SEL_MSG;
      idx = 16'(msg_loaded[$urandom_range(msg_loaded.size() - 1)]
                + MSG_ENTRIES * $urandom_range(127));
    end else if (roll < 35 && chain_loaded.size() > 0) begin
      sel = SEL_CHN;
      idx = 16'(chain_loaded[$urandom_range(chain_loaded.size() - 1)]
                + CHN_ENTRIES * $urandom_range(255));
    end else if (roll < 42) begin
      sel = SEL_KEEP;
      idx = 16'($urandom);
    end else if (roll < 45) begin
      sel = SEL_KEEP_ALT;
      idx = 16'($urandom);
    end else begin
      sel = 3'($urandom_range(SRC_PIN_OUT, SRC_PIN_A));
      idx = pick_gate();
    end
  endfunction

  task automatic send_item(input gate_item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drive_item <= it;
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    // remember which store entries may now be read
    if (it.opcode == OPC_LOAD_MSG && !msg_seen[it.load_index]) begin
      msg_seen[it.load_index] = 1'b1;
      msg_loaded = {msg_loaded, int'(it.load_index)};
    end
    if (it.opcode == OPC_LOAD_CHN && it.load_index < CHN_ENTRIES
        && !chain_seen[it.load_index]) begin
      chain_seen[it.load_index] = 1'b1;
      chain_loaded = {chain_loaded, int'(it.load_index)};
    end
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int          done;
    int          roll;
    int          idx;
    gate_item_t  it;
    logic [1:0]  op;
    logic [15:0] gref;
    logic [2:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    logic [15:0] i1;
    logic [15:0] i2;
    logic [15:0] i3;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        it = make_load(OPC_LOAD_MSG, $urandom_range(MSG_ENTRIES - 1), $urandom());
        done++;
      end else if (roll < 20) begin
        // some chain loads fall above the store and are dropped
        if ($urandom_range(4) == 0) idx = $urandom_range(511, CHN_ENTRIES);
        else idx = $urandom_range(CHN_ENTRIES - 1);
        it = make_load(OPC_LOAD_CHN, idx, $urandom());
        if (idx < CHN_ENTRIES) done++;
      end else if (roll < 22) begin
        it = make_load(OPC_UNUSED, $urandom_range(511), $urandom());
      end else begin
        pick_source(s1, i1);
        pick_source(s2, i2);
        pick_source(s3, i3);
        gref = pick_gate();
        op   = 2'($urandom_range(GOP_ADD, GOP_XOR3));
        // follow an add with the next gate so the carry pin gets used
        if (last_add_gate >= 0 && $urandom_range(99) < 40) begin
          gref = 16'(last_add_gate + 1);
          s3   = SEL_KEEP;
        end
        it = make_exec(op, gref, s1, i1, s2, i2, s3, i3);
        last_add_gate = (op == GOP_ADD) ? int'(gref) : -1;
        done++;
      end
      send_item(it);
    end
  endtask

  initial begin
    int phase_idle [4];
    tracker       = new();
    drive_item    = make_load(OPC_LOAD_MSG, 0, '0);
    start         = 1'b0;
    rst_n         = 1'b0;
    idle_pct      = 0;
    last_add_gate = -1;
    quiet_cycles  = 0;
    phase_idle    = '{0, 75, 0, 9};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // store extremes, dropped chain loads and the unused opcode
    send_item(make_load(OPC_LOAD_MSG, 0, 32'hFFFF_FFFF));
    send_item(make_load(OPC_LOAD_MSG, 511, 32'h0000_0000));
    send_item(make_load(OPC_LOAD_MSG, 16'h0AA, 32'hA5A5_A5A5));
    send_item(make_load(OPC_LOAD_CHN, 0, 32'h1234_5678));
    send_item(make_load(OPC_LOAD_CHN, 255, 32'hFFFF_FFFF));
    send_item(make_load(OPC_LOAD_CHN, 256, 32'hDEAD_BEEF));
    send_item(make_load(OPC_LOAD_CHN, 511, 32'h0000_0001));
    send_item(make_load(OPC_UNUSED, 511, 32'hFFFF_FFFF));
    // xor3, choose and majority, reading the constant gate and wrapped store indices
    send_item(make_exec(GOP_XOR3, 16'd1, SRC_PIN_OUT, 16'd0, SEL_MSG, 16'hFE00,
                        SEL_CHN, 16'hFFFF));
    send_item(make_exec(GOP_CHOOSE, 16'd2, SEL_MSG, 16'h00AA, SRC_PIN_B, 16'd0,
                        SEL_CHN, 16'h0100));
    send_item(make_exec(GOP_MAJ, 16'd3, SRC_PIN_OUT, 16'd1, SRC_PIN_OUT, 16'd2,
                        SEL_MSG, 16'h01FF));
    // add on the last gate carries into gate 0
    send_item(make_exec(GOP_ADD, 16'hFFFF, SRC_PIN_OUT, 16'd0, SEL_MSG, 16'd0,
                        SEL_CHN, 16'd255));
    send_item(make_exec(GOP_XOR3, 16'd4, SRC_PIN_C, 16'd0, SEL_KEEP, 16'hFFFF,
                        SEL_KEEP_ALT, 16'd0));
    // carry chain into the next gate's kept third pin
    send_item(make_exec(GOP_ADD, 16'd5, SEL_MSG, 16'h00AA, SEL_CHN, 16'd0,
                        SRC_PIN_B, 16'd0));
    send_item(make_exec(GOP_ADD, 16'd6, SRC_PIN_OUT, 16'd5, SEL_MSG, 16'h00AA,
                        SEL_KEEP, 16'd0));
    // later operands read this gate's freshly written pins
    send_item(make_exec(GOP_CHOOSE, 16'd7, SEL_CHN, 16'd0, SRC_PIN_A, 16'd7,
                        SRC_PIN_B, 16'd7));
    // overwrite the constant gate, then read it back
    send_item(make_exec(GOP_MAJ, 16'd0, SEL_MSG, 16'd511, SEL_KEEP_ALT, 16'hFFFF,
                        SEL_KEEP, 16'hFFFF));
    send_item(make_exec(GOP_XOR3, 16'd8, SRC_PIN_OUT, 16'd0, SRC_PIN_A, 16'hFFFF,
                        SRC_PIN_B, 16'h8000));
    send_item(make_exec(GOP_ADD, 16'hFFFF, SEL_KEEP, 16'd0, SEL_KEEP, 16'd0,
                        SEL_KEEP, 16'd0));

    // random traffic under each sender idling pattern
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      run_random(RANDOM_ITEMS / 4);
    end
    start <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0)
      $display("[packed_gate_netlist_evaluator_unit] OK");
    else
      $display("[packed_gate_netlist_evaluator_unit] ERROR");
    $finish;
  end
endmodule
